/* design/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants of the line rasterizer: request and result
// items, the classified command that passes from front to back, line modes.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned DeltaW   = CoordW + 1;
  localparam int unsigned ErrW     = CoordW + 2;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 2;

  localparam logic [ColorW-1:0] ColorReset = '1;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_VERT = 2'd0,
    MODE_HORZ = 2'd1,
    MODE_XMAJ = 2'd2,
    MODE_YMAJ = 2'd3
  } line_mode_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    req_type_e req_type;
    coord_t    start_x;
    coord_t    start_y;
    coord_t    end_x;
    coord_t    end_y;
  } in_item_t;

  typedef struct packed {
    coord_t              pixel_x;
    coord_t              pixel_y;
    logic [ColorW-1:0]   color;
    logic                last_pixel;
  } out_item_t;

  typedef struct packed {
    req_type_e                req_type;
    line_mode_e               mode;
    logic                     busy;
    logic                     first;
    coord_t                   cur_x;
    coord_t                   cur_y;
    coord_t                   tgt_x;
    coord_t                   tgt_y;
    logic [DeltaW-1:0]        abs_dx;
    logic [DeltaW-1:0]        abs_dy;
    logic                     x_neg;
    logic                     y_neg;
    logic signed [ErrW-1:0]   err;
  } cmd_t;

endpackage

/* design/line_rasterizer_unit.sv */
// a request's pixel shows (empty low) once the stepper writes it into the result queue
// throughput: one request per cycle while the result queue has room
// a load or a step on an idle line yields no pixel
// reset (async, active low) empties both queues, clears the line state, color to all ones
// ----------------------------------------------------------------------------
// line_rasterizer_unit
// Bresenham line rasterizer: a classifier front, a command queue, a line
// stepper back and a result queue.
// ----------------------------------------------------------------------------
module line_rasterizer_unit #(
  parameter int unsigned CmdDepth = lr_pkg::CmdDepth,
  parameter int unsigned OutDepth = lr_pkg::OutDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  lr_pkg::in_item_t           in_item_i,
  output logic                       empty,
  input  logic                       pop,
  output lr_pkg::out_item_t          out_item_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lr_pkg::ColorW-1:0]  cfg_data_i
);

  import lr_pkg::*;

  logic [ColorW-1:0] color_q;
  cmd_t              cmd_in, cmd_head;
  logic              cmd_empty, cmd_pop;
  logic              out_full, out_push;
  out_item_t         out_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ColorReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_q <= cfg_data_i;
    end
  end

  lr_front u_front (
    .item_i (in_item_i),
    .cmd_o  (cmd_in)
  );

  lr_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (cmd_in),
    .full_o    (full),
    .pop_i     (cmd_pop),
    .rd_data_o (cmd_head),
    .empty_o   (cmd_empty)
  );

  lr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .color_i     (color_q),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_item_o  (out_item)
  );

  lr_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (out_push),
    .wr_data_i (out_item),
    .full_o    (out_full),
    .pop_i     (pop),
    .rd_data_o (out_item_o),
    .empty_o   (empty)
  );

endmodule

/* design/lr_fifo.sv */
// ----------------------------------------------------------------------------
// lr_fifo
// Small register queue with push/full and pop/empty sides; a push and a pop
// may happen in the same cycle.
// ----------------------------------------------------------------------------
module lr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* design/lr_front.sv */
// ----------------------------------------------------------------------------
// lr_front
// Classifies an incoming request: endpoint deltas, directions, line mode and
// the starting error term of a load.
// ----------------------------------------------------------------------------
module lr_front (
  input  lr_pkg::in_item_t item_i,
  output lr_pkg::cmd_t     cmd_o
);

  import lr_pkg::*;

  logic signed [DeltaW-1:0] dx, dy;
  logic [DeltaW-1:0]        adx, ady;

  always_comb begin
    dx  = $signed({item_i.end_x[CoordW-1], item_i.end_x})
        - $signed({item_i.start_x[CoordW-1], item_i.start_x});
    dy  = $signed({item_i.end_y[CoordW-1], item_i.end_y})
        - $signed({item_i.start_y[CoordW-1], item_i.start_y});
    adx = dx[DeltaW-1] ? -dx : dx;
    ady = dy[DeltaW-1] ? -dy : dy;

    cmd_o.req_type = item_i.req_type;
    cmd_o.cur_x    = item_i.start_x;
    cmd_o.cur_y    = item_i.start_y;
    cmd_o.tgt_x    = item_i.end_x;
    cmd_o.tgt_y    = item_i.end_y;
    cmd_o.abs_dx   = adx;
    cmd_o.abs_dy   = ady;
    cmd_o.x_neg    = dx[DeltaW-1];
    cmd_o.y_neg    = dy[DeltaW-1];
    cmd_o.err      = '0;
    cmd_o.first    = 1'b0;
    cmd_o.busy     = 1'b1;

    if (adx == '0) begin
      cmd_o.mode = MODE_VERT;
      cmd_o.busy = (ady != '0);
    end else if (ady == '0) begin
      cmd_o.mode = MODE_HORZ;
    end else if (adx >= ady) begin
      cmd_o.mode  = MODE_XMAJ;
      cmd_o.first = 1'b1;
      cmd_o.err   = $signed({2'b00, adx[DeltaW-1:1]});
    end else begin
      cmd_o.mode  = MODE_YMAJ;
      cmd_o.first = 1'b1;
      cmd_o.err   = $signed({2'b00, ady[DeltaW-1:1]});
    end
  end

endmodule

/* design/lr_back.sv */
// ----------------------------------------------------------------------------
// lr_back
// Line stepper: holds the active line and, per step request, produces the
// next pixel, with a Bresenham error update on sloped lines.
// ----------------------------------------------------------------------------
module lr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  lr_pkg::cmd_t               cmd_i,
  output logic                       cmd_pop_o,
  input  logic [lr_pkg::ColorW-1:0]  color_i,
  input  logic                       out_full_i,
  output logic                       out_push_o,
  output lr_pkg::out_item_t          out_item_o
);

  import lr_pkg::*;

  line_mode_e             mode_q, mode_d;
  logic                   busy_q, busy_d;
  logic                   first_q, first_d;
  coord_t                 cur_x_q, cur_x_d;
  coord_t                 cur_y_q, cur_y_d;
  coord_t                 tgt_x_q, tgt_x_d;
  coord_t                 tgt_y_q, tgt_y_d;
  logic [DeltaW-1:0]      adx_q, adx_d;
  logic [DeltaW-1:0]      ady_q, ady_d;
  logic                   x_neg_q, x_neg_d;
  logic                   y_neg_q, y_neg_d;
  logic signed [ErrW-1:0] err_q, err_d;

  coord_t                 nx, ny;
  logic signed [ErrW-1:0] ex, ey;
  logic                   last;

  assign cmd_pop_o = cmd_valid_i && !out_full_i;

  always_comb begin
    mode_d  = mode_q;
    busy_d  = busy_q;
    first_d = first_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    tgt_x_d = tgt_x_q;
    tgt_y_d = tgt_y_q;
    adx_d   = adx_q;
    ady_d   = ady_q;
    x_neg_d = x_neg_q;
    y_neg_d = y_neg_q;
    err_d   = err_q;
    last    = 1'b0;

    nx = x_neg_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
    ny = y_neg_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
    ex = err_q - $signed({1'b0, ady_q});
    ey = err_q - $signed({1'b0, adx_q});

    out_push_o = 1'b0;
    out_item_o.pixel_x    = cur_x_q;
    out_item_o.pixel_y    = cur_y_q;
    out_item_o.color      = color_i;
    out_item_o.last_pixel = 1'b0;

    if (cmd_pop_o) begin
      if (cmd_i.req_type == REQ_LOAD) begin
        mode_d  = cmd_i.mode;
        busy_d  = cmd_i.busy;
        first_d = cmd_i.first;
        cur_x_d = cmd_i.cur_x;
        cur_y_d = cmd_i.cur_y;
        tgt_x_d = cmd_i.tgt_x;
        tgt_y_d = cmd_i.tgt_y;
        adx_d   = cmd_i.abs_dx;
        ady_d   = cmd_i.abs_dy;
        x_neg_d = cmd_i.x_neg;
        y_neg_d = cmd_i.y_neg;
        err_d   = cmd_i.err;
      end else if (busy_q) begin
        out_push_o = 1'b1;
        case (mode_q)
          MODE_VERT: begin
            cur_y_d = ny;
            last    = (ny == tgt_y_q);
          end
          MODE_HORZ: begin
            cur_x_d = nx;
            last    = (nx == tgt_x_q);
          end
          MODE_XMAJ: begin
            if (first_q) begin
              first_d = 1'b0;
            end else begin
              cur_x_d = nx;
              if (ex < 0) begin
                cur_y_d = ny;
                err_d   = ex + $signed({1'b0, adx_q});
              end else begin
                err_d   = ex;
              end
              out_item_o.pixel_x = cur_x_d;
              out_item_o.pixel_y = cur_y_d;
              last = (nx == tgt_x_q);
            end
          end
          MODE_YMAJ: begin
            if (first_q) begin
              first_d = 1'b0;
            end else begin
              cur_y_d = ny;
              if (ey < 0) begin
                cur_x_d = nx;
                err_d   = ey + $signed({1'b0, ady_q});
              end else begin
                err_d   = ey;
              end
              out_item_o.pixel_x = cur_x_d;
              out_item_o.pixel_y = cur_y_d;
              last = (ny == tgt_y_q);
            end
          end
          default: begin
            busy_d = 1'b0;
          end
        endcase
        out_item_o.last_pixel = last;
        if (last) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_VERT;
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      adx_q   <= '0;
      ady_q   <= '0;
      x_neg_q <= 1'b0;
      y_neg_q <= 1'b0;
      err_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      busy_q  <= busy_d;
      first_q <= first_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      tgt_x_q <= tgt_x_d;
      tgt_y_q <= tgt_y_d;
      adx_q   <= adx_d;
      ady_q   <= ady_d;
      x_neg_q <= x_neg_d;
      y_neg_q <= y_neg_d;
      err_q   <= err_d;
    end
  end

endmodule

/* design/lr_checker.sv */
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input lr_pkg::in_item_t           in_item_i,
  input logic                       empty,
  input logic                       pop,
  input lr_pkg::out_item_t          out_item_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [lr_pkg::ColorW-1:0]  cfg_data_i
);

  import lr_pkg::*;

  logic [ColorW-1:0] color_q;
  logic [31:0]       steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ColorReset;
      steps_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_data_i;
      end
      steps_q <= steps_q
               + 32'((push && !full && in_item_i.req_type == REQ_STEP) ? 1 : 0)
               - 32'((pop && !empty) ? 1 : 0);
    end
  end

  // nothing waits right after reset
  a_empty_after_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  // a waiting pixel holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed before pop");

  // every pixel carries the last written color
  a_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.color == color_q))
    else $error("pixel color differs from configured color");

  // no pixel without an earlier step request
  a_no_extra_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) |-> (steps_q != '0))
    else $error("pixel delivered without a step request");

endmodule

bind line_rasterizer_unit lr_checker u_lr_checker (.*);

/* tb/line_rasterizer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_unit_tb
// Drives load and step requests into the line rasterizer and checks every
// pixel against a Bresenham line tracker kept in the bench. It covers
// vertical, horizontal and sloped lines, zero-length lines, steps while idle
// and loads over an active line. It also covers the color register,
// backpressure that fills the block, and random lines with random gaps on
// both sides.
// ----------------------------------------------------------------------------
module line_rasterizer_unit_tb;
  import lr_pkg::*;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 10;
  localparam int RandomTarget = 1050;
  localparam int CoordMin     = -(1 << (CoordW - 1));
  localparam int CoordMax     = (1 << (CoordW - 1)) - 1;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              push        = 1'b0;
  logic              full;
  in_item_t          in_item     = '0;
  logic              empty;
  logic              pop         = 1'b0;
  out_item_t         out_item;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ColorW-1:0] cfg_data_i  = '0;

  // line tracker state
  logic [ColorW-1:0] pixel_color = ColorReset;
  int                line_x, line_y, goal_x, goal_y;
  int                run_dx, run_dy, dir_x, dir_y, slope_err;
  line_mode_e        line_shape = MODE_VERT;
  bit                line_busy, start_due;

  out_item_t pending_pixels[$];
  int        applied_requests;
  int        mismatches;
  int        cycle_count;
  int        pop_hold_req;
  bit        no_idle;

  line_rasterizer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int random_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic int clamp_coord(int c);
    return (c > CoordMax) ? CoordMax : ((c < CoordMin) ? CoordMin : c);
  endfunction

  function automatic void rasterize_request(in_item_t r);
    out_item_t px;
    int        ddx, ddy;
    if (r.req_type == REQ_LOAD) begin
      line_x    = $signed(r.start_x);
      line_y    = $signed(r.start_y);
      goal_x    = $signed(r.end_x);
      goal_y    = $signed(r.end_y);
      ddx       = goal_x - line_x;
      ddy       = goal_y - line_y;
      run_dx    = (ddx < 0) ? -ddx : ddx;
      run_dy    = (ddy < 0) ? -ddy : ddy;
      dir_x     = (ddx > 0) ? 1 : ((ddx < 0) ? -1 : 0);
      dir_y     = (ddy > 0) ? 1 : ((ddy < 0) ? -1 : 0);
      start_due = 1'b0;
      slope_err = 0;
      if (run_dx == 0) begin
        line_shape = MODE_VERT;
        line_busy  = (run_dy != 0);
      end else if (run_dy == 0) begin
        line_shape = MODE_HORZ;
        line_busy  = 1'b1;
      end else begin
        line_shape = (run_dx >= run_dy) ? MODE_XMAJ : MODE_YMAJ;
        slope_err  = ((line_shape == MODE_XMAJ) ? run_dx : run_dy) / 2;
        start_due  = 1'b1;
        line_busy  = 1'b1;
      end
      applied_requests++;
      return;
    end
    if (!line_busy) return;
    applied_requests++;
    px.pixel_x    = coord_t'(line_x);
    px.pixel_y    = coord_t'(line_y);
    px.color      = pixel_color;
    px.last_pixel = 1'b0;
    case (line_shape)
      MODE_VERT: begin
        line_y += dir_y;
        px.last_pixel = (line_y == goal_y);
      end
      MODE_HORZ: begin
        line_x += dir_x;
        px.last_pixel = (line_x == goal_x);
      end
      MODE_XMAJ: begin
        if (start_due) begin
          start_due = 1'b0;
        end else begin
          line_x    += dir_x;
          slope_err -= run_dy;
          if (slope_err < 0) begin
            line_y    += dir_y;
            slope_err += run_dx;
          end
          px.pixel_x    = coord_t'(line_x);
          px.pixel_y    = coord_t'(line_y);
          px.last_pixel = (line_x == goal_x);
        end
      end
      default: begin
        if (start_due) begin
          start_due = 1'b0;
        end else begin
          line_y    += dir_y;
          slope_err -= run_dx;
          if (slope_err < 0) begin
            line_x    += dir_x;
            slope_err += run_dy;
          end
          px.pixel_x    = coord_t'(line_x);
          px.pixel_y    = coord_t'(line_y);
          px.last_pixel = (line_y == goal_y);
        end
      end
    endcase
    if (px.last_pixel) line_busy = 1'b0;
    pending_pixels.push_back(px);
  endfunction

  task automatic send_request(in_item_t r);
    int gap;
    gap = no_idle ? 0 : (($urandom_range(0, 2) == 0) ? random_gap() : 0);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= r;
    do @(posedge clk_i); while (full);
    rasterize_request(r);
  endtask

  task automatic load_line(int sx, int sy, int ex, int ey);
    in_item_t r;
    r          = $bits(in_item_t)'({$urandom, $urandom});
    r.req_type = REQ_LOAD;
    r.start_x  = coord_t'(sx);
    r.start_y  = coord_t'(sy);
    r.end_x    = coord_t'(ex);
    r.end_y    = coord_t'(ey);
    send_request(r);
  endtask

  // step requests carry random endpoint bits, which the block ignores
  task automatic step_line(int n);
    in_item_t r;
    for (int i = 0; i < n; i++) begin
      r          = $bits(in_item_t)'({$urandom, $urandom});
      r.req_type = REQ_STEP;
      send_request(r);
    end
  endtask

  task automatic wait_block_idle();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_color(logic [ColorW-1:0] c);
    wait_block_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pixel_color = c;
  endtask

  task automatic compare_pixel(out_item_t got);
    out_item_t exp;
    if (pending_pixels.size() == 0) begin
      $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%0b", $time,
               got.pixel_x, got.pixel_y, got.color, got.last_pixel);
      mismatches++;
      return;
    end
    exp = pending_pixels.pop_front();
    if (got.pixel_x !== exp.pixel_x) begin
      $display("%0t: pixel_x expected %0d got %0d", $time, exp.pixel_x, got.pixel_x);
      mismatches++;
    end
    if (got.pixel_y !== exp.pixel_y) begin
      $display("%0t: pixel_y expected %0d got %0d", $time, exp.pixel_y, got.pixel_y);
      mismatches++;
    end
    if (got.color !== exp.color) begin
      $display("%0t: color expected %h got %h", $time, exp.color, got.color);
      mismatches++;
    end
    if (got.last_pixel !== exp.last_pixel) begin
      $display("%0t: last_pixel expected %0b got %0b", $time, exp.last_pixel,
               got.last_pixel);
      mismatches++;
    end
  endtask

  // pixel receiver with random stalls and requested hold-offs
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) compare_pixel(out_item);
      if (pop_hold_req > 0) begin
        hold_left    = pop_hold_req;
        pop_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) gap_left = random_gap();
      end
    end
  end

  task automatic test_directed_lines();
    load_line(5, -3, 5, 0);
    step_line(3);
    load_line(CoordMax, CoordMin, CoordMax - 3, CoordMin);
    step_line(3);
    load_line(0, 0, 3, 1);
    step_line(4);
    load_line(0, 0, -1, -3);
    step_line(4);
    // equal deltas run x major
    load_line(0, 0, 2, 2);
    step_line(3);
    load_line(CoordMin, CoordMin, CoordMax, CoordMax);
    step_line(1);
    // zero length over an active line, then a step while idle
    load_line(7, 7, 7, 7);
    step_line(1);
  endtask

  task automatic test_color_register();
    logic [ColorW-1:0] colors[4];
    colors = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A, $urandom};
    foreach (colors[i]) begin
      write_color(colors[i]);
      load_line(-10, 4, -6, 6);
      step_line(5);
    end
  endtask

  task automatic test_backpressure();
    pop_hold_req = 120;
    no_idle      = 1'b1;
    load_line(0, 100, 40, 100);
    step_line(40);
    no_idle = 1'b0;
  endtask

  task automatic send_random_line();
    in_item_t                 r;
    logic [$bits(in_item_t)-1:0] raw;
    int kind, len, minor, sx, sy, ex, ey, adx, ady, pixels, steps;
    if ($urandom_range(0, 19) == 0) begin
      raw = $bits(in_item_t)'({$urandom, $urandom});
      r   = raw;
      send_request(r);
      return;
    end
    len  = ($urandom_range(0, 24) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
    kind = $urandom_range(0, 9);
    sx   = $urandom_range(0, 4095) + CoordMin;
    sy   = $urandom_range(0, 4095) + CoordMin;
    if ($urandom_range(0, 7) == 0) sx = $urandom_range(0, 1) ? CoordMax : CoordMin;
    if ($urandom_range(0, 7) == 0) sy = $urandom_range(0, 1) ? CoordMax : CoordMin;
    minor = $urandom_range(1, len);
    case (kind)
      0, 1: begin
        ex = sx;
        ey = $urandom_range(0, 1) ? sy + len : sy - len;
      end
      2, 3: begin
        ex = $urandom_range(0, 1) ? sx + len : sx - len;
        ey = sy;
      end
      9: begin
        ex = sx;
        ey = sy;
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          ex = $urandom_range(0, 1) ? sx + len : sx - len;
          ey = $urandom_range(0, 1) ? sy + minor : sy - minor;
        end else begin
          ex = $urandom_range(0, 1) ? sx + minor : sx - minor;
          ey = $urandom_range(0, 1) ? sy + len : sy - len;
        end
      end
    endcase
    ex  = clamp_coord(ex);
    ey  = clamp_coord(ey);
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    if (adx == 0 || ady == 0) pixels = adx + ady;
    else pixels = ((adx > ady) ? adx : ady) + 1;
    case ($urandom_range(0, 9))
      0:       steps = (pixels > 0) ? $urandom_range(0, pixels - 1) : 0;
      1:       steps = pixels + $urandom_range(1, 2);
      default: steps = pixels;
    endcase
    load_line(sx, sy, ex, ey);
    step_line(steps);
  endtask

  task automatic test_random_lines();
    int target;
    applied_requests = 0;
    for (int seg = 0; seg < 4; seg++) begin
      write_color($urandom);
      no_idle = (seg == 2);
      target  = (seg + 1) * RandomTarget / 4;
      while (applied_requests < target) send_random_line();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_lines();
    test_color_register();
    test_backpressure();
    test_random_lines();
    wait_block_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
design/lr_pkg.sv
design/lr_fifo.sv
design/lr_front.sv
design/lr_back.sv
design/line_rasterizer_unit.sv
design/lr_checker.sv
tb/line_rasterizer_unit_tb.sv
